### design/ptsg_pkg.sv
// Package for the pulse/triangle tone generator: request codes, address codes,
// and fixed constants shared by the front, the divider and the voice engine.
// No dependencies.
package ptsg_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [4:0] ADDR_P0_CTRL   = 5'd0;
  localparam logic [4:0] ADDR_P0_SWEEP  = 5'd1;
  localparam logic [4:0] ADDR_P0_LO     = 5'd2;
  localparam logic [4:0] ADDR_P0_HI     = 5'd3;
  localparam logic [4:0] ADDR_P1_CTRL   = 5'd4;
  localparam logic [4:0] ADDR_P1_SWEEP  = 5'd5;
  localparam logic [4:0] ADDR_P1_LO     = 5'd6;
  localparam logic [4:0] ADDR_P1_HI     = 5'd7;
  localparam logic [4:0] ADDR_TRI_LEN   = 5'd8;
  localparam logic [4:0] ADDR_TRI_LO    = 5'd10;
  localparam logic [4:0] ADDR_TRI_HI    = 5'd11;

  // Clock constants times ten for the phase step numerators.
  localparam logic [20:0] PULSE_CLK_X10 = 21'd1118608;
  localparam logic [20:0] TRI_CLK_X10   = 21'd559304;
  localparam logic [18:0] RATE_X10      = 19'd441000;

  // Classified item that travels through the queue.
  typedef struct packed {
    req_t       req;
    logic [4:0] addr;
    logic [7:0] data;
  } item_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic        tri_sel;
    logic [10:0] period;
  } div_req_t;

endpackage

### design/ptsg_front.sv
// Front part: accepts request words and keeps them in a short queue.
// Depends on ptsg_pkg.
module ptsg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ptsg_pkg::item_t      in_item,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ptsg_pkg::item_t      q_item
);
  import ptsg_pkg::*;

  item_t      mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 3'd4);
  assign q_valid  = (count != 3'd0);
  assign q_item   = mem[rd_ptr];
  // Requests of kind three are dropped here: they need no back-end work.
  assign push     = in_valid && in_ready && (in_item.req != REQ_NONE);
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 3'd4 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 3'd0 |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 3'd1) else $error("count step");
`endif

endmodule

### design/ptsg_div.sv
// Restoring divider for phase steps: floor(clk_x10 * 2^PB / (441000*(p+1))).
// One quotient bit per cycle. Depends on ptsg_pkg.
module ptsg_div #(
  parameter int PHASE_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ptsg_pkg::div_req_t        req,
  output logic                      busy,
  output logic                      done,
  output logic [PHASE_BITS-1:0]     quot
);
  import ptsg_pkg::*;

  localparam int NUM_W = 21 + PHASE_BITS;
  localparam int DEN_W = 30;
  localparam int CW    = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [PHASE_BITS-1:0] q;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   shifted;

  // Only the low PHASE_BITS quotient bits are kept.
  assign quot    = q;
  assign shifted = {rem[DEN_W-1:0], num[NUM_W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        num  <= {(req.tri_sel ? TRI_CLK_X10 : PULSE_CLK_X10), {PHASE_BITS{1'b0}}};
        den  <= DEN_W'(RATE_X10 * ({19'd0, req.period} + 30'd1));
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (!trial[DEN_W]) begin
          rem <= trial;
          q   <= {q[PHASE_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[PHASE_BITS-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
`endif

endmodule

### design/ptsg_voice.sv
// Back part: channel state, register writes, sweep ticks and sample mixing.
// Depends on ptsg_pkg and ptsg_div.
module ptsg_voice #(
  parameter int PHASE_BITS     = 24,
  parameter int SWEEP_INTERVAL = 100000,
  parameter int LENGTH_SCALE   = 10000
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  ptsg_pkg::item_t     q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  out_sample
);
  import ptsg_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam logic [PB-1:0] HALF = {1'b1, {(PB-1){1'b0}}};

  // Pulse level for each volume step: (v * 32768 + 7) / 15.
  localparam logic [16:0] AMP_LUT [16] = '{
    17'd0,     17'd2185,  17'd4369,  17'd6554,  17'd8738,  17'd10923,
    17'd13107, 17'd15292, 17'd17476, 17'd19661, 17'd21845, 17'd24030,
    17'd26214, 17'd28399, 17'd30583, 17'd32768
  };

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_WAIT, S_SWEEP, S_SWEEP_DIV, S_P0, S_P1, S_TRI,
    S_SCALE, S_OUT
  } state_t;

  state_t state;
  item_t  cur;
  logic   sweep_ch;

  logic [1:0]    duty   [2];
  logic [3:0]    vol    [2];
  logic [10:0]   per    [2];
  logic [PB-1:0] ph     [2];
  logic [PB-1:0] stp    [2];
  logic          sw_en  [2];
  logic          sw_neg [2];
  logic [2:0]    sw_sh  [2];
  logic [16:0]   sw_wait[2];
  logic [19:0]   plen   [2];
  logic [10:0]   tper;
  logic [PB-1:0] tph;
  logic [PB-1:0] tstp;
  logic [21:0]   tlen;

  logic signed [18:0] acc;
  logic signed [31:0] prod;
  logic               div_tri;
  logic               div_ch;
  logic               div_start;
  logic [10:0]        div_period;
  logic               div_launch;

  div_req_t         dreq;
  logic             dbusy;
  logic             ddone;
  logic [PB-1:0]    dquot;

  assign dreq = '{start: div_start, tri_sel: div_tri, period: div_period};

  ptsg_div #(.PHASE_BITS(PB)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .done(ddone), .quot(dquot)
  );

  // Combinational helpers for the channel handled in the current state.
  logic          pc;
  logic [10:0]   pp;
  logic [10:0]   amt;
  logic [11:0]   np_add;
  logic [10:0]   np_sub;
  logic          sw_fail;
  logic [PB-1:0] thr;
  logic [16:0]   amp;
  logic signed [18:0] pv;
  logic [PB-1:0] tf;
  logic signed [18:0] tv;
  logic signed [18:0] clamped;
  logic [10:0]   wr_per;

  always_comb begin
    if (state == S_P1)      pc = 1'b1;
    else if (state == S_P0) pc = 1'b0;
    else                    pc = sweep_ch;
    pp     = per[pc];
    amt    = pp >> sw_sh[pc];
    np_add = {1'b0, pp} + {1'b0, amt};
    np_sub = pp - amt;
    if (sw_neg[pc]) sw_fail = (np_sub < 11'd8);
    else            sw_fail = (np_add > 12'h7ff) || (np_add < 12'd8);
    thr = (duty[pc] == 2'd0) ? (HALF >> 2) : (PB'(duty[pc]) << (PB - 2));
    amp = AMP_LUT[vol[pc]];
    pv  = (ph[pc] > thr) ? $signed({2'b0, amp}) : -$signed({2'b0, amp});
    tf  = (tph > HALF) ? (PB'(0) - tph) : tph;
    tv  = $signed(19'(tf >> (PB - 15))) - 19'sd8192;
    if (acc > 19'sd32768)       clamped = 19'sd32768;
    else if (acc < -19'sd32768) clamped = -19'sd32768;
    else                        clamped = acc;
    wr_per = 11'd0;
    if (cur.addr == ADDR_P0_LO || cur.addr == ADDR_P1_LO)
      wr_per = {per[cur.addr[2]][10:8], cur.data};
    else if (cur.addr == ADDR_P0_HI || cur.addr == ADDR_P1_HI)
      wr_per = {1'b0, cur.data[1:0], per[cur.addr[2]][7:0]};
    else if (cur.addr == ADDR_TRI_LO)
      wr_per = {tper[10:8], cur.data};
    else
      wr_per = {1'b0, cur.data[1:0], tper[7:0]};
    // A divider pass starts for a period write or for a sweep that moves the period.
    div_launch = 1'b0;
    if (state == S_DIV_WAIT && !ddone && !dbusy && !div_start) begin
      if (cur.addr < 5'd8) div_launch = cur.addr[1];
      else div_launch = (cur.addr == ADDR_TRI_LO) || (cur.addr == ADDR_TRI_HI);
    end else if (state == S_SWEEP && sw_en[pc] && sw_wait[pc] == 17'd0 && !sw_fail) begin
      div_launch = 1'b1;
    end
  end

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      sweep_ch  <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        duty[c] <= '0; vol[c] <= '0; per[c] <= '0; ph[c] <= '0; stp[c] <= '0;
        sw_en[c] <= 1'b0; sw_neg[c] <= 1'b0; sw_sh[c] <= '0; sw_wait[c] <= '0;
        plen[c] <= '0;
      end
      tper <= '0; tph <= '0; tstp <= '0; tlen <= '0;
    end else begin
      div_start <= div_launch;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            unique case (q_item.req)
              REQ_WRITE:  state <= S_DIV_WAIT;
              REQ_TICK: begin
                sweep_ch <= 1'b0;
                state    <= S_SWEEP;
              end
              REQ_SAMPLE: begin
                acc   <= '0;
                state <= S_P0;
              end
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_DIV_WAIT: begin
          // Register write; period writes launch the divider then wait.
          if (ddone) begin
            if (div_tri) tstp <= dquot;
            else         stp[div_ch] <= dquot;
            state <= S_IDLE;
          end else if (!dbusy && !div_start) begin
            if (!div_launch) state <= S_IDLE;
            if (cur.addr < 5'd8) begin
              priority case (cur.addr[1:0])
                2'd0: begin
                  duty[cur.addr[2]] <= cur.data[7:6];
                  vol[cur.addr[2]]  <= cur.data[4] ? cur.data[3:0] : 4'd0;
                end
                2'd1: begin
                  sw_en[cur.addr[2]]   <= cur.data[7];
                  sw_neg[cur.addr[2]]  <= cur.data[3];
                  sw_sh[cur.addr[2]]   <= cur.data[2:0];
                  sw_wait[cur.addr[2]] <= '0;
                end
                default: begin
                  per[cur.addr[2]] <= wr_per;
                  if (cur.addr[1:0] == 2'd3) begin
                    ph[cur.addr[2]]   <= '0;
                    plen[cur.addr[2]] <= 20'(cur.data[7:3] * LENGTH_SCALE);
                  end
                  div_period <= wr_per;
                  div_tri    <= 1'b0;
                  div_ch     <= cur.addr[2];
                end
              endcase
            end else if (cur.addr == ADDR_TRI_LEN) begin
              tlen <= 22'(cur.data[6:0] * LENGTH_SCALE);
            end else if (cur.addr == ADDR_TRI_LO || cur.addr == ADDR_TRI_HI) begin
              tper <= wr_per;
              if (cur.addr == ADDR_TRI_HI) tph <= '0;
              div_period <= wr_per;
              div_tri    <= 1'b1;
            end
          end
        end
        S_SWEEP: begin
          sweep_ch <= 1'b1;
          if (div_launch) state <= S_SWEEP_DIV;
          else            state <= sweep_ch ? S_IDLE : S_SWEEP;
          if (sw_en[pc]) begin
            if (sw_wait[pc] != 17'd0) begin
              sw_wait[pc] <= sw_wait[pc] - 17'd1;
            end else begin
              sw_wait[pc] <= 17'(SWEEP_INTERVAL);
              if (sw_fail) begin
                vol[pc]   <= '0;
                sw_en[pc] <= 1'b0;
              end else begin
                per[pc]    <= sw_neg[pc] ? np_sub : np_add[10:0];
                div_period <= sw_neg[pc] ? np_sub : np_add[10:0];
                div_tri    <= 1'b0;
                div_ch     <= pc;
              end
            end
          end
        end
        S_SWEEP_DIV: begin
          if (ddone) begin
            stp[div_ch] <= dquot;
            state       <= div_ch ? S_IDLE : S_SWEEP;
            sweep_ch    <= 1'b1;
          end
        end
        S_P0, S_P1: begin
          if (pp > 11'd7) begin
            acc    <= acc + pv;
            ph[pc] <= ph[pc] + stp[pc];
            if (plen[pc] == 20'd0) per[pc] <= '0;
            else                   plen[pc] <= plen[pc] - 20'd1;
          end
          state <= (state == S_P0) ? S_P1 : S_TRI;
        end
        S_TRI: begin
          if (tper != 11'd0) begin
            acc <= acc + tv;
            tph <= tph + tstp;
            if (tlen == 22'd0) tper <= '0;
            else               tlen <= tlen - 22'd1;
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= 32'(clamped) * 32'sd16000;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            // Truncate toward zero: bias negatives before the shift.
            out_sample <= 15'((prod + (prod[31] ? 32'sd32767 : 32'sd0)) >>> 15);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_sample <= 15'sd16000 && out_sample >= -15'sd16000))
    else $error("sample out of range");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !dbusy) else $error("divider started while busy");
`endif

endmodule

### design/pulse_triangle_sound_generator_top.sv
// Top level of the pulse/triangle tone generator.
// Depends on ptsg_pkg, ptsg_front, ptsg_voice (and ptsg_div below it).
//
// Usage: each input word on the s_axis channel is one request. tuser carries
// req_type (0 register write, 1 sweep tick, 2 sample request); tdata carries
// reg_addr in bits 4:0 and write_data in bits 12:5. Only a sample request
// produces an output word on m_axis: a signed 15-bit sample in tdata.
// A front queue of four words accepts requests while the back end works; an
// accepted word is registered in the queue and waits there until the back end
// is idle. A plain register write is applied directly; a period write also
// waits for a divider pass (one quotient bit per cycle); a sweep tick visits
// both pulse channels and runs a divider pass for each one whose period moves;
// a sample request sums both pulse channels and the triangle, scales the sum
// and registers it on m_axis.
// The output register holds a sample until m_axis_tready; while it waits,
// the back end stops at the next sample and the queue fills, then
// s_axis_tready drops. Reset (rst, synchronous) clears all channel state,
// empties the queue and drops the output valid.
module pulse_triangle_sound_generator_top #(
  parameter int PHASE_BITS     = 24,
  parameter int SWEEP_INTERVAL = 100000,
  parameter int LENGTH_SCALE   = 10000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // reg_addr[4:0], write_data[12:5]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // sample[14:0]
);
  import ptsg_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;
  logic signed [14:0] sample;

  // Unpack the request word into the queue item.
  assign in_item.req  = req_t'(s_axis_tuser);
  assign in_item.addr = s_axis_tdata[4:0];
  assign in_item.data = s_axis_tdata[12:5];

  ptsg_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  ptsg_voice #(
    .PHASE_BITS(PHASE_BITS), .SWEEP_INTERVAL(SWEEP_INTERVAL),
    .LENGTH_SCALE(LENGTH_SCALE)
  ) u_voice (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_sample(sample)
  );

  assign m_axis_tdata = {1'b0, sample};

endmodule
